// ----- hw/rtl/tcdd_pkg.sv -----
`default_nettype none

package tcdd_pkg;

  localparam int unsigned DgBytes = 16;
  localparam int unsigned CntW    = $clog2(DgBytes + 2);
  localparam int unsigned IdxW    = $clog2(DgBytes);

  // datagram framing and command bytes
  localparam logic [7:0] HdrByte0   = 8'h7E;
  localparam logic [7:0] HdrByte1   = 8'h19;
  localparam logic [7:0] TrlByte    = 8'hE7;
  localparam logic [7:0] CmdSet     = 8'h03;
  localparam logic [7:0] CmdRelease = 8'h04;
  localparam logic [7:0] CmdNudge   = 8'h05;
  localparam logic [7:0] SubManual  = 8'h01;
  localparam logic [7:0] SubAuto    = 8'h02;

  // nudge directions
  localparam logic [7:0] DirUp    = 8'h01;
  localparam logic [7:0] DirDown  = 8'h02;
  localparam logic [7:0] DirLeft  = 8'h03;
  localparam logic [7:0] DirRight = 8'h04;

  // result status codes
  localparam logic [2:0] StManual  = 3'd0;
  localparam logic [2:0] StAuto    = 3'd1;
  localparam logic [2:0] StRelease = 3'd2;
  localparam logic [2:0] StNudged  = 3'd3;
  localparam logic [2:0] StRefused = 3'd4;
  localparam logic [2:0] StOther   = 3'd5;

  // tracking modes
  localparam logic [1:0] ModeMulti  = 2'd0;
  localparam logic [1:0] ModeManual = 2'd1;
  localparam logic [1:0] ModeAuto   = 2'd2;

  // configuration register indexes
  localparam logic [7:0] CfgWindow = 8'd0;
  localparam logic [7:0] CfgExtent = 8'd1;

  localparam logic [15:0] ExtentReset = 16'd512;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [1:0]  mode;
    logic [15:0] target;
    logic [17:0] left;
    logic [17:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic        reinit;
  } tcdd_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcdd_core.sv -----
`default_nettype none

module tcdd_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 opcode_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 eod_i,
  input  wire logic [15:0]          trk_left_i,
  input  wire logic [15:0]          trk_top_i,
  input  wire logic [15:0]          trk_width_i,
  input  wire logic [15:0]          trk_height_i,
  input  wire logic [7:0]           window_i,
  input  wire logic [15:0]          extent_i,
  output tcdd_pkg::tcdd_result_t    res_o
);
  import tcdd_pkg::*;

  logic [7:0]      store_q [DgBytes];
  logic [7:0]      b       [DgBytes];
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [1:0]      mode_q, mode_d;
  logic [15:0]     tgt_q, tgt_d;
  logic [17:0]     hx_q, hx_d, hy_q, hy_d;
  logic [15:0]     hw_q, hw_d, hh_q, hh_d;
  logic [8:0]      bx_q, bx_d, by_q, by_d;
  logic [17:0]     cl_q, ct_q;
  logic [15:0]     cw_q, ch_q;

  logic            byte_step, dg_done, dg_ok, tracking;
  logic [2:0]      status;
  logic [8:0]      stride;
  logic [8:0]      step_x, step_y;
  logic [17:0]     nx, ny, bl, bt;
  logic            x_bad, y_bad;

  assign byte_step = step_i && !opcode_i;
  assign cnt_inc   = (cnt_q <= CntW'(DgBytes)) ? cnt_q + 1'b1 : cnt_q;
  assign cnt_d     = eod_i ? '0 : cnt_inc;

  // store as it stands once this word is written
  always_comb begin
    for (int i = 0; i < DgBytes; i++) begin
      b[i] = (cnt_q == CntW'(i)) ? data_byte_i : store_q[i];
    end
  end

  assign dg_done = byte_step && eod_i;
  assign dg_ok   = (cnt_inc == CntW'(DgBytes)) && b[0] == HdrByte0 && b[1] == HdrByte1 &&
                   b[DgBytes-1] == TrlByte && b[3] == window_i;

  assign stride = {1'b0, b[5]};

  // nudge bias; an unknown direction keeps the last one
  always_comb begin
    step_x = bx_q;
    step_y = by_q;
    if (b[4] == DirUp) begin
      step_x = '0;
      step_y = -stride;
    end else if (b[4] == DirDown) begin
      step_x = '0;
      step_y = stride;
    end else if (b[4] == DirLeft) begin
      step_x = -stride;
      step_y = '0;
    end else if (b[4] == DirRight) begin
      step_x = stride;
      step_y = '0;
    end
  end

  assign nx     = cl_q + {{9{step_x[8]}}, step_x};
  assign ny     = ct_q + {{9{step_y[8]}}, step_y};
  // box must stay inside the frame, otherwise that axis falls back
  assign x_bad  = nx[17] || (({1'b0, nx[16:0]} + {2'b0, cw_q}) > {2'b0, extent_i});
  assign y_bad  = ny[17] || (({1'b0, ny[16:0]} + {2'b0, ch_q}) > {2'b0, extent_i});

  always_comb begin
    mode_d = mode_q;
    tgt_d  = tgt_q;
    hx_d   = hx_q;
    hy_d   = hy_q;
    hw_d   = hw_q;
    hh_d   = hh_q;
    bx_d   = bx_q;
    by_d   = by_q;
    status = StOther;
    if (b[2] == CmdSet) begin
      if (b[14] == SubManual || b[14] == SubAuto) begin
        hx_d = {2'b0, b[4], b[5]};
        hy_d = {2'b0, b[6], b[7]};
        hw_d = {b[8], b[9]};
        hh_d = {b[10], b[11]};
        if (b[14] == SubAuto) begin
          tgt_d  = {b[12], b[13]};
          mode_d = ModeAuto;
          status = StAuto;
        end else begin
          mode_d = ModeManual;
          status = StManual;
        end
      end
    end else if (b[2] == CmdRelease) begin
      mode_d = ModeMulti;
      status = StRelease;
    end else if (b[2] == CmdNudge) begin
      if (mode_q == ModeManual || mode_q == ModeAuto) begin
        bx_d   = step_x;
        by_d   = step_y;
        hx_d   = x_bad ? cl_q : nx;
        hy_d   = y_bad ? ct_q : ny;
        hw_d   = cw_q;
        hh_d   = ch_q;
        mode_d = ModeManual;
        status = StNudged;
      end else begin
        status = StRefused;
      end
    end
  end

  assign tracking = mode_d == ModeManual || mode_d == ModeAuto;
  assign bl       = hx_d - {3'b0, hw_d[15:1]};
  assign bt       = hy_d - {3'b0, hh_d[15:1]};

  always_comb begin
    res_o        = '0;
    res_o.valid  = dg_done && dg_ok;
    res_o.status = status;
    res_o.mode   = mode_d;
    res_o.target = tgt_d;
    res_o.reinit = tracking;
    if (tracking) begin
      res_o.left   = bl;
      res_o.top    = bt;
      res_o.width  = hw_d;
      res_o.height = hh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_step && cnt_q < CntW'(DgBytes)) begin
      store_q[cnt_q[IdxW-1:0]] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= ModeMulti;
      tgt_q  <= '0;
      hx_q   <= '0;
      hy_q   <= '0;
      hw_q   <= '0;
      hh_q   <= '0;
      bx_q   <= '0;
      by_q   <= '0;
      cl_q   <= '0;
      ct_q   <= '0;
      cw_q   <= '0;
      ch_q   <= '0;
    end else if (step_i) begin
      if (opcode_i) begin
        cl_q <= {{2{trk_left_i[15]}}, trk_left_i};
        ct_q <= {{2{trk_top_i[15]}}, trk_top_i};
        cw_q <= trk_width_i;
        ch_q <= trk_height_i;
      end else begin
        cnt_q <= cnt_d;
        if (dg_done && dg_ok) begin
          mode_q <= mode_d;
          tgt_q  <= tgt_d;
          hx_q   <= hx_d;
          hy_q   <= hy_d;
          hw_q   <= hw_d;
          hh_q   <= hh_d;
          bx_q   <= bx_d;
          by_q   <= by_d;
          if (tracking) begin
            cl_q <= bl;
            ct_q <= bt;
            cw_q <= hw_d;
            ch_q <= hh_d;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/track_command_datagram_decoder.sv -----
`default_nettype none

// Channel  Dir  Fields (low bit first)
// s_axis   in   tdata: data_byte, left, top, width, height; tuser: opcode; tlast: eod
// m_axis   out  tdata: mode, target, left, top, width, height, reinit, pad; tuser: status
// cfg      in   index 0 window_number, 1 frame_extent; always ready
//
// One word per cycle sustained while no result waits on m_axis. A word goes into an
// input register and is decoded from there; its result lands in the output register
// once that register is free, and the result shows from the output register.
// Reset (rst_ni low, async) clears counters, tracking state and both valids.
// A result waiting on m_axis stalls decode; an empty input register still takes one word.

module track_command_datagram_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // data_byte, left, top, width, height
  input  wire logic [0:0]  s_axis_tuser,   // opcode
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // mode, target, left, top, w, h, reinit, pad
  output logic [2:0]       m_axis_tuser,   // status
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import tcdd_pkg::*;

  logic         in_valid_q, in_valid_d;
  logic [71:0]  in_data_q;
  logic         in_op_q, in_last_q;
  logic         out_valid_q, out_valid_d;
  logic [87:0]  out_data_q;
  logic [2:0]   out_status_q;
  logic [7:0]   window_q;
  logic [15:0]  extent_q;
  logic         out_free, proc;
  tcdd_result_t res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = (out_valid_q && !m_axis_tready) || (proc && res.valid);

  tcdd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (proc),
    .opcode_i     (in_op_q),
    .data_byte_i  (in_data_q[7:0]),
    .eod_i        (in_last_q),
    .trk_left_i   (in_data_q[23:8]),
    .trk_top_i    (in_data_q[39:24]),
    .trk_width_i  (in_data_q[55:40]),
    .trk_height_i (in_data_q[71:56]),
    .window_i     (window_q),
    .extent_i     (extent_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      window_q    <= '0;
      extent_q    <= ExtentReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgWindow) begin
          window_q <= cfg_data_i[7:0];
        end else if (cfg_index_i == CfgExtent) begin
          extent_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_op_q   <= s_axis_tuser[0];
      in_last_q <= s_axis_tlast;
    end
    if (proc && res.valid) begin
      out_status_q <= res.status;
      out_data_q   <= {1'b0, res.reinit, res.height, res.width, res.top, res.left,
                       res.target, res.mode};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tcdd_checker.sv -----
`default_nettype none

module tcdd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);
  import tcdd_pkg::*;

  logic [1:0] mode;
  logic       reinit;

  assign mode   = m_axis_tdata[1:0];
  assign reinit = m_axis_tdata[86];

  // a stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result word changed under stall");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> reinit == (mode == ModeManual || mode == ModeAuto))
    else $error("reinit does not match tracking mode");

  a_nobox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !reinit |-> m_axis_tdata[85:18] == '0)
    else $error("box fields set while not tracking");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StRelease |-> mode == ModeMulti)
    else $error("release left tracking on");

  a_nudge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StNudged |-> mode == ModeManual)
    else $error("nudge did not switch to manual");

endmodule

bind track_command_datagram_decoder tcdd_checker u_tcdd_checker (.*);

`default_nettype wire
